FILE: rtl/fel_pkg.sv
// Shared constants, types and controller/datapath command structs for the feedback echo.
package fel_pkg;

    localparam int MAX_DELAY    = 16384;
    localparam int MAX_CHANNELS = 2;
    localparam int FRAC_BITS    = 16;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 17;
    localparam int LEN_W    = $clog2(MAX_DELAY) + 1;
    localparam int POS_W    = $clog2(MAX_DELAY);
    localparam int CH_W     = 1;
    localparam int ADDR_W   = $clog2(MAX_DELAY * MAX_CHANNELS);
    localparam int DEPTH    = MAX_DELAY * MAX_CHANNELS;
    localparam int WORD_W   = 32;
    localparam int CFG_W    = 2;
    localparam int CFG_DW   = 17;

    localparam int MUL_A_W  = WORD_W + 1;
    localparam int MUL_B_W  = GAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SHR_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W    = SHR_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << FRAC_BITS;
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_DELAY);

    localparam logic [LEN_W-1:0]       RST_DELAY_LENGTH   = LEN_W'(14400);
    localparam logic [GAIN_W-1:0]      RST_DECAY_GAIN     = GAIN_W'(45875);
    localparam logic [GAIN_W-1:0]      RST_DAMPING_WEIGHT = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]      RST_WET_GAIN       = GAIN_W'(65536);

    typedef enum logic [CFG_W-1:0] {
        CFG_DELAY_LENGTH   = 2'd0,
        CFG_DECAY_GAIN     = 2'd1,
        CFG_DAMPING_WEIGHT = 2'd2,
        CFG_WET_GAIN       = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_PREV,
        S_RD_CUR,
        S_MUL_P,
        S_MUL_Q,
        S_SUM,
        S_MUL_D,
        S_SAT,
        S_DIFF,
        S_MUL_W,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd_cur;
        logic ld_prev;
        logic mul_p;
        logic mul_q;
        logic sum;
        logic mul_d;
        logic sat_wr;
        logic diff;
        logic mul_w;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/fel_in_if.sv
// Input channel: one sample beat with channel index and frame end flag.
interface fel_in_if;
    import fel_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CH_W-1:0]            channel;
    logic                       frame_end;

    modport source(output valid, output sample_in, output channel, output frame_end,
                   input ready);
    modport sink(input valid, input sample_in, input channel, input frame_end,
                 output ready);
endinterface

FILE: rtl/fel_out_if.sv
// Output channel: one echoed sample beat.
interface fel_out_if;
    import fel_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source(output valid, output sample_out, input ready);
    modport sink(input valid, input sample_out, output ready);
endinterface

FILE: rtl/fel_ctrl.sv
// Sequencer for the echo datapath: clearing pass, read/multiply/write steps, output hand-off.
module fel_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fel_pkg::t_status i_status,
    output fel_pkg::t_cmd    o_cmd
);
    import fel_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_RD_PREV;
            end
            S_RD_PREV: n_state = S_RD_CUR;
            S_RD_CUR:  n_state = S_MUL_P;
            S_MUL_P:   n_state = S_MUL_Q;
            S_MUL_Q:   n_state = S_SUM;
            S_SUM:     n_state = S_MUL_D;
            S_MUL_D:   n_state = S_SAT;
            S_SAT:     n_state = S_DIFF;
            S_DIFF:    n_state = S_MUL_W;
            S_MUL_W:   n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:   o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_RD_PREV: o_cmd.rd_cur  = 1'b0;
            S_RD_CUR: begin
                o_cmd.rd_cur  = 1'b1;
                o_cmd.ld_prev = 1'b1;
            end
            S_MUL_P:   o_cmd.mul_p  = 1'b1;
            S_MUL_Q:   o_cmd.mul_q  = 1'b1;
            S_SUM:     o_cmd.sum    = 1'b1;
            S_MUL_D:   o_cmd.mul_d  = 1'b1;
            S_SAT:     o_cmd.sat_wr = 1'b1;
            S_DIFF:    o_cmd.diff   = 1'b1;
            S_MUL_W:   o_cmd.mul_w  = 1'b1;
            S_OUT:     o_cmd.out_ld = i_status.out_free;
            default:   o_cmd        = '0;
        endcase
    end

endmodule

FILE: rtl/fel_dp.sv
// Echo datapath: config registers, delay RAM, shared multiplier, saturation and output register.
module fel_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fel_pkg::CFG_W-1:0]           i_cfg_idx,
    input  logic [fel_pkg::CFG_DW-1:0]          i_cfg_data,
    input  logic signed [fel_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [fel_pkg::CH_W-1:0]            i_channel,
    input  logic                                i_frame_end,
    input  fel_pkg::t_cmd                       i_cmd,
    output fel_pkg::t_status                    o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [fel_pkg::SAMPLE_W-1:0] o_sample_out
);
    import fel_pkg::*;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) return hi[WORD_W-1:0];
        if (v < lo) return lo[WORD_W-1:0];
        return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) return hi[SAMPLE_W-1:0];
        if (v < lo) return lo[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

    // configuration
    logic [LEN_W-1:0]  r_delay_length;
    logic [GAIN_W-1:0] r_decay_gain;
    logic [GAIN_W-1:0] r_damping_weight;
    logic [GAIN_W-1:0] r_wet_gain;

    // position and clearing
    logic [POS_W-1:0]  r_wpos;
    logic [ADDR_W-1:0] r_clr;

    // per-item state
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_frame_end;
    logic [POS_W-1:0]           r_pos;
    logic [LEN_W-1:0]           r_len;
    logic [ADDR_W-1:0]          r_addr_cur;
    logic [ADDR_W-1:0]          r_addr_prev;

    // arithmetic
    logic signed [MUL_A_W-1:0] r_mul_a;
    logic signed [MUL_B_W-1:0] r_mul_b;
    logic signed [MUL_A_W-1:0] r_p;
    logic signed [MUL_A_W-1:0] r_q;
    logic signed [SHR_W-1:0]   r_m;
    logic signed [WORD_W-1:0]  r_y;

    // memory
    logic [WORD_W-1:0] mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rdata;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [GAIN_W-1:0]         w_damp;
    logic [GAIN_W-1:0]         w_decay;
    logic [GAIN_W-1:0]         w_wet;
    logic [LEN_W-1:0]          w_len;
    logic [POS_W-1:0]          w_pos;
    logic [POS_W-1:0]          w_prev;
    logic [LEN_W-1:0]          w_base;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SHR_W-1:0]   w_mul;
    logic signed [SUM_W-1:0]   w_ysum;
    logic signed [SUM_W-1:0]   w_osum;
    logic signed [WORD_W-1:0]  w_y;
    logic [LEN_W-1:0]          w_pos_inc;
    logic [ADDR_W-1:0]         w_raddr;
    logic [ADDR_W-1:0]         w_waddr;
    logic [WORD_W-1:0]         w_wdata;
    logic                      w_we;

    assign w_damp  = (r_damping_weight > GAIN_ONE) ? GAIN_ONE : r_damping_weight;
    assign w_decay = (r_decay_gain > GAIN_ONE) ? GAIN_ONE : r_decay_gain;
    assign w_wet   = (r_wet_gain > GAIN_ONE) ? GAIN_ONE : r_wet_gain;

    always_comb begin
        if (r_delay_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_delay_length > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_delay_length;
        end
    end

    assign w_pos  = ({1'b0, r_wpos} >= w_len) ? '0 : r_wpos;
    assign w_prev = (w_pos == '0) ? POS_W'(w_len - LEN_W'(1)) : w_pos - POS_W'(1);
    assign w_base = (i_channel != '0) ? w_len : '0;

    assign w_prod = PROD_W'(r_mul_a) * PROD_W'(r_mul_b);
    assign w_mul  = w_prod[PROD_W-1:FRAC_BITS];

    assign w_ysum = SUM_W'(r_x) + SUM_W'(r_m);
    assign w_y    = sat32(w_ysum);
    assign w_osum = SUM_W'(r_x) + SUM_W'(r_m);

    assign w_pos_inc = {1'b0, r_pos} + LEN_W'(1);

    assign w_raddr = i_cmd.rd_cur ? r_addr_cur : r_addr_prev;
    assign w_we    = i_cmd.clr_wr | i_cmd.sat_wr;
    assign w_waddr = i_cmd.clr_wr ? r_clr : r_addr_cur;
    assign w_wdata = i_cmd.clr_wr ? '0 : w_y;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length   <= RST_DELAY_LENGTH;
            r_decay_gain     <= RST_DECAY_GAIN;
            r_damping_weight <= RST_DAMPING_WEIGHT;
            r_wet_gain       <= RST_WET_GAIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DELAY_LENGTH:   r_delay_length   <= i_cfg_data[LEN_W-1:0];
                CFG_DECAY_GAIN:     r_decay_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_DAMPING_WEIGHT: r_damping_weight <= i_cfg_data[GAIN_W-1:0];
                CFG_WET_GAIN:       r_wet_gain       <= i_cfg_data[GAIN_W-1:0];
                default:            r_wet_gain       <= r_wet_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
                if (r_frame_end) begin
                    r_wpos <= (w_pos_inc == r_len) ? '0 : w_pos_inc[POS_W-1:0];
                end else begin
                    r_wpos <= r_pos;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x         <= i_sample_in;
            r_frame_end <= i_frame_end;
            r_pos       <= w_pos;
            r_len       <= w_len;
            r_addr_cur  <= ADDR_W'(w_base) + ADDR_W'(w_pos);
            r_addr_prev <= ADDR_W'(w_base) + ADDR_W'(w_prev);
        end
        if (i_cmd.ld_prev) begin
            r_mul_a <= MUL_A_W'($signed(r_rdata));
            r_mul_b <= $signed({1'b0, w_damp});
        end
        if (i_cmd.mul_p) begin
            r_p     <= w_mul[MUL_A_W-1:0];
            r_mul_a <= MUL_A_W'($signed(r_rdata));
            r_mul_b <= $signed({1'b0, GAIN_ONE - w_damp});
        end
        if (i_cmd.mul_q) begin
            r_q <= w_mul[MUL_A_W-1:0];
        end
        if (i_cmd.sum) begin
            r_mul_a <= r_p + r_q;
            r_mul_b <= $signed({1'b0, w_decay});
        end
        if (i_cmd.mul_d || i_cmd.mul_w) begin
            r_m <= w_mul;
        end
        if (i_cmd.sat_wr) begin
            r_y <= w_y;
        end
        if (i_cmd.diff) begin
            r_mul_a <= MUL_A_W'(r_y) - MUL_A_W'(r_x);
            r_mul_b <= $signed({1'b0, w_wet});
        end
        if (i_cmd.out_ld) begin
            r_out <= clamp16(w_osum);
        end
    end

    assign o_status.clr_done = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out;

endmodule

FILE: rtl/feedback_echo_lowpass.sv
// Top level of the multichannel feedback echo with damping lowpass.
// Each sample taken in S_IDLE is worked through by the sequencer stepping one shared
// multiplier four times and the delay RAM through two reads and a write, then loaded
// into the output register once it is free; no new sample is taken before then.
// Reset: synchronous active low; a clearing pass then zeroes the 32768-word delay RAM,
// one word a cycle, before the first sample beat is taken.
module feedback_echo_lowpass (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fel_pkg::CFG_W-1:0]        i_cfg_idx,
    input  logic [fel_pkg::CFG_DW-1:0]       i_cfg_data,
    fel_in_if.sink                           i_in,
    fel_out_if.source                        o_out
);
    import fel_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fel_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .i_channel    (i_in.channel),
        .i_frame_end  (i_in.frame_end),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out)
    );

endmodule
